// File: sv/ascii_can_frame_parser_core_macros.svh
// ============================================================================
// ASCII CAN frame parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef ASCII_CAN_FRAME_PARSER_CORE_MACROS_SVH
`define ASCII_CAN_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication.
`define ACFP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ACFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/acfp_pkg.sv
// ============================================================================
// ASCII CAN frame parser package
// Character codes, flag positions, widths and the hex digit decoder.
// ============================================================================
package acfp_pkg;

    localparam logic [7:0] CH_DELIM = 8'h23;   // '#'
    localparam logic [7:0] CH_SEP   = 8'h2E;   // '.'
    localparam logic [7:0] CH_UR    = 8'h52;   // 'R'
    localparam logic [7:0] CH_LR    = 8'h72;   // 'r'
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    localparam logic [3:0] POS_STD_DELIM = 4'd3;
    localparam logic [3:0] POS_EXT_DELIM = 4'd8;
    localparam logic [3:0] POS_STD_DATA  = 4'd4;
    localparam logic [3:0] POS_EXT_DATA  = 4'd9;
    localparam logic [3:0] POS_MAX       = 4'd15;
    localparam logic [3:0] MAX_BYTES     = 4'd8;

    localparam int BIT_EXT = 31;
    localparam int BIT_RTR = 30;
    localparam int BIT_ERR = 29;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 104;

    typedef enum logic [2:0] {
        FMT_NONE = 3'b001,
        FMT_STD  = 3'b010,
        FMT_EXT  = 3'b100
    } fmt_t;

    // Returns 0..15 for a hex digit and 16 for anything else.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] tmp;
        logic [4:0] v;
        begin
            tmp = 8'd0;
            v   = 5'd16;
            if (c >= CH_0 && c <= CH_9) begin
                tmp = c - CH_0;
                v   = {1'b0, tmp[3:0]};
            end else if (c >= CH_UA && c <= CH_UF) begin
                tmp = c - CH_UA + 8'd10;
                v   = {1'b0, tmp[3:0]};
            end else if (c >= CH_LA && c <= CH_LF) begin
                tmp = c - CH_LA + 8'd10;
                v   = {1'b0, tmp[3:0]};
            end
            return v;
        end
    endfunction

endpackage

// File: sv/ascii_can_frame_parser_core.sv
// The frame result is registered: it appears in the cycle after its last character.
// Throughput: one character per cycle unless the output stalls; the per-character parse
// update is a single short combinational step between parse state and result registers.
// Reset (rst_n low, asynchronous) clears the parse state and drops the output valid.
// After each frame's last character the parse state returns to its reset value.
// ============================================================================
// ASCII CAN frame parser core
// Parses text of the form <id>#{R|data} one character per item and emits one
// frame result (id word, byte count, payload, status) on the last character.
// ============================================================================
`include "ascii_can_frame_parser_core_macros.svh"

module ascii_can_frame_parser_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input stream.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [acfp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,   // [7:0] character
    input  logic                                  s_axis_tlast,   // is_last
    // Output stream.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [31:0] id_word, [35:32] byte_count, [99:36] payload, [103:100] zero
    output logic [acfp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tuser    // status
);

    // ------------------------------------------------------------------
    // Parse state. Every accepted character updates it.
    // ------------------------------------------------------------------
    logic [3:0]     char_pos_reg,  char_pos_next;
    logic [31:0]    id_acc_reg,    id_acc_next;
    acfp_pkg::fmt_t fmt_reg,       fmt_next;
    logic [63:0]    data_reg,      data_next;
    logic [3:0]     bytes_reg,     bytes_next;
    logic           nib_pend_reg,  nib_pend_next;
    logic           sep_used_reg,  sep_used_next;
    logic           err_reg,       err_next;
    logic           closed_reg,    closed_next;
    logic           rtr_reg,       rtr_next;

    // Result register.
    logic           out_valid_reg;
    logic [31:0]    out_id_reg;
    logic [3:0]     out_count_reg;
    logic [63:0]    out_payload_reg;
    logic           out_status_reg;

    logic [7:0]     ch;
    logic [4:0]     nib;
    logic           nib_ok;
    logic [3:0]     data_start;
    logic [5:0]     byte_shift;
    logic           in_fire;
    logic           frame_err;
    logic [31:0]    frame_id;

    assign ch         = s_axis_tdata[7:0];
    assign nib        = acfp_pkg::hex_value(ch);
    assign nib_ok     = !nib[4];
    assign data_start = (fmt_reg == acfp_pkg::FMT_STD) ? acfp_pkg::POS_STD_DATA
                                                        : acfp_pkg::POS_EXT_DATA;
    // Byte lane of the byte being built; bytes_reg never passes eight.
    assign byte_shift = {bytes_reg[2:0], 3'b000};

    // The result register can always take a new item once its contents leave.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Per-character update. Identifier digits come first until a delimiter
    // at position three or eight fixes the format; after that come either an
    // RTR mark or the data bytes. Errors freeze all but the position count until the end.
    // ------------------------------------------------------------------
    always_comb
    begin
        char_pos_next = char_pos_reg;
        id_acc_next   = id_acc_reg;
        fmt_next      = fmt_reg;
        data_next     = data_reg;
        bytes_next    = bytes_reg;
        nib_pend_next = nib_pend_reg;
        sep_used_next = sep_used_reg;
        err_next      = err_reg;
        closed_next   = closed_reg;
        rtr_next      = rtr_reg;

        if (!err_reg) begin
            if (fmt_reg == acfp_pkg::FMT_NONE) begin
                if (ch == acfp_pkg::CH_DELIM && char_pos_reg == acfp_pkg::POS_STD_DELIM) begin
                    fmt_next = acfp_pkg::FMT_STD;
                end else if (ch == acfp_pkg::CH_DELIM
                             && char_pos_reg == acfp_pkg::POS_EXT_DELIM) begin
                    fmt_next = acfp_pkg::FMT_EXT;
                end else if (char_pos_reg >= acfp_pkg::POS_EXT_DELIM || !nib_ok) begin
                    err_next = 1'b1;
                end else begin
                    id_acc_next = {id_acc_reg[27:0], nib[3:0]};
                end
            end else if (!closed_reg) begin
                if (char_pos_reg == data_start
                    && (ch == acfp_pkg::CH_UR || ch == acfp_pkg::CH_LR)) begin
                    rtr_next    = 1'b1;
                    closed_next = 1'b1;
                end else if (!nib_pend_reg) begin
                    if (ch == acfp_pkg::CH_SEP && !sep_used_reg) begin
                        sep_used_next = 1'b1;
                    end else if (!nib_ok) begin
                        err_next = 1'b1;
                    end else begin
                        // High nibble of the current byte.
                        data_next     = data_reg | ({56'd0, nib[3:0], 4'd0} << byte_shift);
                        nib_pend_next = 1'b1;
                    end
                end else if (!nib_ok) begin
                    err_next = 1'b1;
                end else begin
                    // Low nibble completes the byte.
                    data_next     = data_reg | ({60'd0, nib[3:0]} << byte_shift);
                    nib_pend_next = 1'b0;
                    sep_used_next = 1'b0;
                    bytes_next    = bytes_reg + 4'd1;
                    if (bytes_reg + 4'd1 >= acfp_pkg::MAX_BYTES) begin
                        closed_next = 1'b1;
                    end
                end
            end
        end

        if (char_pos_reg < acfp_pkg::POS_MAX) begin
            char_pos_next = char_pos_reg + 4'd1;
        end
    end

    // ------------------------------------------------------------------
    // Frame result, formed from the state after the last character.
    // Text that never reached a delimiter or stops mid-byte is malformed.
    // ------------------------------------------------------------------
    always_comb
    begin
        frame_err = err_next || (fmt_next == acfp_pkg::FMT_NONE) || nib_pend_next;
        frame_id  = id_acc_next;
        if (fmt_next == acfp_pkg::FMT_STD) begin
            frame_id = {20'd0, id_acc_next[11:0]};
        end else if (!id_acc_next[acfp_pkg::BIT_ERR]) begin
            frame_id[acfp_pkg::BIT_EXT] = 1'b1;
        end
        if (rtr_next) begin
            frame_id[acfp_pkg::BIT_RTR] = 1'b1;
        end
    end

    // Parse state: cleared after the last character of each frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            char_pos_reg <= 4'd0;
            id_acc_reg   <= 32'd0;
            fmt_reg      <= acfp_pkg::FMT_NONE;
            data_reg     <= 64'd0;
            bytes_reg    <= 4'd0;
            nib_pend_reg <= 1'b0;
            sep_used_reg <= 1'b0;
            err_reg      <= 1'b0;
            closed_reg   <= 1'b0;
            rtr_reg      <= 1'b0;
        end else if (in_fire) begin
            if (s_axis_tlast) begin
                char_pos_reg <= 4'd0;
                id_acc_reg   <= 32'd0;
                fmt_reg      <= acfp_pkg::FMT_NONE;
                data_reg     <= 64'd0;
                bytes_reg    <= 4'd0;
                nib_pend_reg <= 1'b0;
                sep_used_reg <= 1'b0;
                err_reg      <= 1'b0;
                closed_reg   <= 1'b0;
                rtr_reg      <= 1'b0;
            end else begin
                char_pos_reg <= char_pos_next;
                id_acc_reg   <= id_acc_next;
                fmt_reg      <= fmt_next;
                data_reg     <= data_next;
                bytes_reg    <= bytes_next;
                nib_pend_reg <= nib_pend_next;
                sep_used_reg <= sep_used_next;
                err_reg      <= err_next;
                closed_reg   <= closed_next;
                rtr_reg      <= rtr_next;
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire && s_axis_tlast) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload; a malformed frame carries zero fields.
    always_ff @(posedge clk)
    begin
        if (in_fire && s_axis_tlast) begin
            out_status_reg  <= frame_err;
            out_id_reg      <= frame_err ? 32'd0 : frame_id;
            out_count_reg   <= frame_err ? 4'd0  : bytes_next;
            out_payload_reg <= frame_err ? 64'd0 : data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_payload_reg, out_count_reg, out_id_reg};
    assign m_axis_tuser  = out_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ACFP_ASSERT_IMPLY(a_err_zero, out_valid_reg && out_status_reg, out_id_reg == 32'd0 && out_count_reg == 4'd0 && out_payload_reg == 64'd0, "malformed frame has nonzero fields")
    `ACFP_ASSERT_IMPLY(a_bytes_max, 1'b1, bytes_reg <= acfp_pkg::MAX_BYTES, "byte count past eight")
    `ACFP_ASSERT_IMPLY(a_pend_fmt, nib_pend_reg, fmt_reg != acfp_pkg::FMT_NONE, "data nibble before delimiter")
    `ACFP_ASSERT_NEXT(a_last_clears, in_fire && s_axis_tlast, out_valid_reg && char_pos_reg == 4'd0 && !err_reg, "last item did not produce a result or clear state")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// ASCII CAN frame parser testbench
// Streams frame text one character per item into the parser and checks every
// frame result against a cycle-free model of the parser kept alongside. Short
// directed frames cover the id formats, the remote request, the full payload
// and the malformed cases. Random frames follow, most well formed and some
// damaged. Both stream sides idle at random, and the output side holds off
// for a long stretch once.
// ============================================================================
module testbench;

    localparam int CHAR_TARGET = 1100;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_START  = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 8;

    typedef struct {
        logic [31:0] id_word;
        logic [3:0]  byte_count;
        logic [63:0] payload;
        logic        status;
    } frame_result_t;

    // Tracks the parse of the character stream and holds the frame results
    // that the parser still owes.
    class frame_checker;
        frame_result_t owed[$];
        int            mismatches;
        int            results_seen;

        logic [3:0]     pos;
        logic [31:0]    id_acc;
        acfp_pkg::fmt_t fmt;
        logic [63:0]    data;
        logic [3:0]     nbytes;
        bit             half_byte;
        bit             dot_used;
        bit             bad;
        bit             closed;
        bit             remote;

        function void clear();
            pos       = '0;
            id_acc    = '0;
            fmt       = acfp_pkg::FMT_NONE;
            data      = '0;
            nbytes    = '0;
            half_byte = 1'b0;
            dot_used  = 1'b0;
            bad       = 1'b0;
            closed    = 1'b0;
            remote    = 1'b0;
        endfunction

        function new();
            mismatches   = 0;
            results_seen = 0;
            clear();
        endfunction

        // Nibble value of a hex digit, or 16 when the character is no digit.
        function logic [4:0] digit_of(logic [7:0] c);
            logic [7:0] d;
            d = 8'd16;
            if (c >= acfp_pkg::CH_0 && c <= acfp_pkg::CH_9)
            begin
                d = c - acfp_pkg::CH_0;
            end
            else if (c >= acfp_pkg::CH_UA && c <= acfp_pkg::CH_UF)
            begin
                d = c - acfp_pkg::CH_UA + 8'd10;
            end
            else if (c >= acfp_pkg::CH_LA && c <= acfp_pkg::CH_LF)
            begin
                d = c - acfp_pkg::CH_LA + 8'd10;
            end
            return d[4:0];
        endfunction

        function void note_char(logic [7:0] c, bit is_last);
            logic [4:0]    nib;
            logic [3:0]    data_start;
            int            lane;
            frame_result_t res;
            nib  = digit_of(c);
            lane = int'(nbytes[2:0]) * 8;
            if (!bad)
            begin
                if (fmt == acfp_pkg::FMT_NONE)
                begin
                    if ((pos == acfp_pkg::POS_STD_DELIM || pos == acfp_pkg::POS_EXT_DELIM)
                        && c == acfp_pkg::CH_DELIM)
                    begin
                        fmt = (pos == acfp_pkg::POS_STD_DELIM) ? acfp_pkg::FMT_STD
                                                               : acfp_pkg::FMT_EXT;
                    end
                    else if (pos >= acfp_pkg::POS_EXT_DELIM || nib[4])
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        id_acc = {id_acc[27:0], nib[3:0]};
                    end
                end
                else if (!closed)
                begin
                    data_start = (fmt == acfp_pkg::FMT_STD) ? acfp_pkg::POS_STD_DATA
                                                             : acfp_pkg::POS_EXT_DATA;
                    if (pos == data_start && (c == acfp_pkg::CH_UR || c == acfp_pkg::CH_LR))
                    begin
                        remote = 1'b1;
                        closed = 1'b1;
                    end
                    else if (!half_byte)
                    begin
                        if (c == acfp_pkg::CH_SEP && !dot_used)
                        begin
                            dot_used = 1'b1;
                        end
                        else if (nib[4])
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            data[lane + 4 +: 4] = nib[3:0];
                            half_byte = 1'b1;
                        end
                    end
                    else if (nib[4])
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        data[lane +: 4] = nib[3:0];
                        half_byte = 1'b0;
                        dot_used  = 1'b0;
                        nbytes    = nbytes + 4'd1;
                        if (nbytes >= acfp_pkg::MAX_BYTES)
                        begin
                            closed = 1'b1;
                        end
                    end
                end
            end
            if (pos < acfp_pkg::POS_MAX)
            begin
                pos = pos + 4'd1;
            end
            if (is_last)
            begin
                // Text that stops before the delimiter or halfway through a
                // byte is malformed.
                if (fmt == acfp_pkg::FMT_NONE || half_byte)
                begin
                    bad = 1'b1;
                end
                if (bad)
                begin
                    res.id_word    = '0;
                    res.byte_count = '0;
                    res.payload    = '0;
                    res.status     = 1'b1;
                end
                else
                begin
                    res.id_word = id_acc;
                    if (fmt == acfp_pkg::FMT_STD)
                    begin
                        res.id_word = id_acc & 32'h0000_0FFF;
                    end
                    else if (!id_acc[acfp_pkg::BIT_ERR])
                    begin
                        res.id_word[acfp_pkg::BIT_EXT] = 1'b1;
                    end
                    if (remote)
                    begin
                        res.id_word[acfp_pkg::BIT_RTR] = 1'b1;
                    end
                    res.byte_count = nbytes;
                    res.payload    = data;
                    res.status     = 1'b0;
                end
                owed.push_back(res);
                clear();
            end
        endfunction

        task report(string field, logic [63:0] got, logic [63:0] want);
            mismatches++;
            $display("Mismatch at result %0d, %s: got %h, expected %h",
                     results_seen, field, got, want);
        endtask

        task check_frame(logic [acfp_pkg::OUT_TDATA_W-1:0] tdata, logic tuser);
            frame_result_t want;
            results_seen++;
            if (owed.size() == 0)
            begin
                report("result with none expected", tdata[63:0], 64'd0);
            end
            else
            begin
                want = owed.pop_front();
                if (tdata[31:0] !== want.id_word)
                begin
                    report("id_word", 64'(tdata[31:0]), 64'(want.id_word));
                end
                if (tdata[35:32] !== want.byte_count)
                begin
                    report("byte_count", 64'(tdata[35:32]), 64'(want.byte_count));
                end
                if (tdata[99:36] !== want.payload)
                begin
                    report("payload", tdata[99:36], want.payload);
                end
                if (tdata[103:100] !== 4'd0)
                begin
                    report("tdata padding", 64'(tdata[103:100]), 64'd0);
                end
                if (tuser !== want.status)
                begin
                    report("status", 64'(tuser), 64'(want.status));
                end
            end
        endtask
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [acfp_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                             s_axis_tlast;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [acfp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tuser;

    frame_checker checker_h = new();
    logic [7:0]   text[$];
    bit           no_idle = 1'b0;
    int           frames_sent = 0;
    int           chars_sent = 0;
    int           damaged = 0;
    int           cycles = 0;

    ascii_can_frame_parser_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycles, checker_h.owed.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Output side: random back-pressure, plus one long hold-off that lets the
    // parser back up into its input.
    initial
    begin : rx_side
        int rx_cycle;
        rx_cycle = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n)
            begin
                rx_cycle++;
            end
            if (!rst_n || (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES))
            begin
                m_axis_tready <= 1'b0;
            end
            else if (no_idle)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= 10);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            checker_h.check_frame(m_axis_tdata, m_axis_tuser);
        end
    end

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(0, 99) < 10);
    endfunction

    function automatic logic [7:0] hex_char();
        logic [7:0] v;
        v = 8'($urandom_range(0, 15));
        if (v < 8'd10)
        begin
            return acfp_pkg::CH_0 + v;
        end
        return ($urandom_range(0, 1) != 0) ? acfp_pkg::CH_UA + v - 8'd10
                                           : acfp_pkg::CH_LA + v - 8'd10;
    endfunction

    // Offers one character and returns at the edge that accepts it.
    task automatic send_char(input logic [7:0] c, input bit is_last);
        @(negedge clk);
        while (idle_now())
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        checker_h.note_char(c, is_last);
        chars_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
        begin
            send_char(text[i], i == text.size() - 1);
        end
        frames_sent++;
    endtask

    task automatic send_string(input string s);
        text.delete();
        for (int i = 0; i < s.len(); i++)
        begin
            text.push_back(s[i]);
        end
        send_text();
    endtask

    task automatic push_junk(input int n);
        repeat (n)
        begin
            text.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Well-formed text with random id, random payload and random separators.
    task automatic build_good_frame();
        int nbytes;
        text.delete();
        repeat (($urandom_range(0, 1) != 0) ? 3 : 8)
        begin
            text.push_back(hex_char());
        end
        text.push_back(acfp_pkg::CH_DELIM);
        if ($urandom_range(0, 99) < 15)
        begin
            text.push_back(($urandom_range(0, 1) != 0) ? acfp_pkg::CH_UR : acfp_pkg::CH_LR);
            push_junk($urandom_range(0, 3));
        end
        else
        begin
            nbytes = $urandom_range(0, 8);
            repeat (nbytes)
            begin
                if ($urandom_range(0, 99) < 30)
                begin
                    text.push_back(acfp_pkg::CH_SEP);
                end
                text.push_back(hex_char());
                text.push_back(hex_char());
            end
            if (nbytes == 8 && $urandom_range(0, 99) < 30)
            begin
                push_junk($urandom_range(1, 4));
            end
        end
    endtask

    // Breaks a frame: a stray byte, a cut, an inserted separator or pure noise.
    task automatic damage_frame();
        int idx;
        idx = $urandom_range(0, text.size() - 1);
        case ($urandom_range(0, 3))
            0: text[idx] = 8'($urandom_range(0, 255));
            1:
            begin
                idx = $urandom_range(1, text.size());
                while (text.size() > idx)
                begin
                    void'(text.pop_back());
                end
            end
            2: text.insert(idx, acfp_pkg::CH_SEP);
            default:
            begin
                text.delete();
                push_junk($urandom_range(1, 14));
                if (text.size() > 8 && $urandom_range(0, 1) != 0)
                begin
                    text[8] = acfp_pkg::CH_DELIM;
                end
                else if (text.size() > 3)
                begin
                    text[3] = acfp_pkg::CH_DELIM;
                end
            end
        endcase
        damaged++;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames: both id formats, remote requests, a full payload
        // with trailing text, and the malformed shapes.
        send_string("1");
        send_string("123#");
        send_string("7FF#R");
        send_string("1fffffff#r.zz");
        send_string("3FFFFFFF#.00.FF");
        send_string("000#1122334455667788XY");
        send_string("abc#a.Bc");
        send_string("123#1");
        send_string("123#..12");
        send_string("12G#");
        send_string("123456789#");
        // A zero character where a data digit belongs.
        text = '{acfp_pkg::CH_0, acfp_pkg::CH_0, acfp_pkg::CH_0, acfp_pkg::CH_DELIM, 8'h00};
        send_text();

        // Random frames, mostly well formed; one stretch runs with no idling.
        while (chars_sent < CHAR_TARGET)
        begin
            no_idle = (frames_sent >= 40 && frames_sent < 55);
            build_good_frame();
            if ($urandom_range(0, 99) < 25)
            begin
                damage_frame();
            end
            send_text();
        end
        no_idle = 1'b0;

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (checker_h.owed.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d frames in %0d characters, %0d of them damaged on purpose.",
                 frames_sent, chars_sent, damaged);
        $display("Checked %0d frame results, %0d mismatches.",
                 checker_h.results_seen, checker_h.mismatches);
        if (checker_h.mismatches == 0 && checker_h.owed.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
